// ===== design/iol_pkg.sv =====
// Shared constants, types and codes for the indexed ordered list.
package iol_pkg;

	localparam int CAPACITY = 16;
	localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;
	localparam int ACTION_W = 3;
	localparam int POS_W    = 8;
	localparam int STATUS_W = 2;
	localparam int LEN_W    = 7;

	typedef logic [CNT_W-1:0]  count_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [DATA_W-1:0] data_t;

	localparam logic [ACTION_W-1:0] ACT_APPEND = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_FRONT  = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_DUMP   = 3'd4;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK     = 2'd0,
		STAT_BADPOS = 2'd1,
		STAT_EMPTY  = 2'd2,
		STAT_FULL   = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SHIFT = 4'b0010,
		S_DUMP  = 4'b0100,
		S_FINAL = 4'b1000
	} state_t;

endpackage

// ===== design/iol_if.sv =====
// Request and response channel interfaces of the indexed ordered list.
interface iol_req_if import iol_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic [ACTION_W-1:0]        action;
	logic signed [DATA_W-1:0]   entry_value;
	logic signed [POS_W-1:0]    position;

	modport source (output valid, output action, output entry_value, output position,
		input ready);
	modport sink (input valid, input action, input entry_value, input position,
		output ready);
endinterface

interface iol_rsp_if import iol_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic [STATUS_W-1:0]        status;
	logic signed [DATA_W-1:0]   item_value;
	logic                       item_valid;
	logic                       last_item;
	logic [LEN_W-1:0]           length;

	modport source (output valid, output status, output item_value, output item_valid,
		output last_item, output length, input ready);
	modport sink (input valid, input status, input item_value, input item_valid,
		input last_item, input length, output ready);
endinterface

// ===== design/indexed_ordered_list.sv =====
// Top level of the indexed ordered list: control sequencer around one entry RAM.
//
// The block keeps an ordered list of up to CAPACITY signed 32-bit entries in a
// synchronous RAM. Each item on the req channel is one action: append, insert at
// the front, insert at a position, delete at a position, or dump. Unknown actions
// are dropped without a response. Every edit returns one item on the rsp channel
// with a status and the new length; a dump returns one item per stored entry in
// list order with last_item set on the final one, or a single item with
// item_valid low when the list is empty.
// Items are handled one at a time. An insert at position p below the length n moves
// the entries from p upward one slot, one entry per cycle through the RAM's read and
// write ports, and then writes the new value. A delete below the last entry moves the
// later entries down one slot the same way. An insert at the end, a delete of the last
// entry, a rejected edit or an empty dump moves nothing and goes straight to the final
// step. A dump streams one entry per cycle while the rsp channel does not stall, each
// read through the RAM's registered output. The next request can be taken in the cycle
// after the last response is loaded. The response sits in an output register; a
// stalled rsp channel holds the sequencer before it loads another response, and no
// response is ever dropped.
// Reset empties the list at once; stale RAM contents are never read.
module indexed_ordered_list import iol_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	iol_req_if.sink   req,
	iol_rsp_if.source rsp
);

	// Sequencer state and list length.
	state_t  state_q, state_d;
	count_t  count_q, count_d;

	// Context of the action in progress.
	status_t stat_q, stat_d;
	logic    is_ins_q, is_ins_d;
	logic    is_del_q, is_del_d;
	data_t   val_q, val_d;
	count_t  pos_q, pos_d;
	addr_t   rd_ptr_q, rd_ptr_d;
	count_t  rem_q, rem_d;

	// A RAM read is pending; its data is on the RAM output now.
	logic    rd_pend_s1, rd_pend_d;
	addr_t   wr_addr_s1, wr_addr_d;
	logic    last_s1, last_d;

	// Output register.
	logic    out_valid_q;
	logic    load;
	status_t out_status_d;
	data_t   out_value_d;
	logic    out_ivalid_d;
	logic    out_last_d;
	status_t out_status_q;
	data_t   out_value_q;
	logic    out_ivalid_q;
	logic    out_last_q;
	logic [LEN_W-1:0] out_len_q;

	// RAM ports.
	logic    ram_we;
	addr_t   ram_waddr;
	data_t   ram_wdata;
	logic    ram_re;
	addr_t   ram_raddr;
	data_t   ram_rdata;

	// Request decode.
	logic [LEN_W-1:0] n7;
	logic [LEN_W-1:0] dec_pos;
	logic    dec_ins;
	logic    dec_del;
	logic    dec_dump;
	logic    dec_neg;
	status_t dec_status;
	count_t  dec_pos_c;
	count_t  cnt_m1;
	count_t  pos_p1;
	logic    accept;
	logic    load_ok;
	logic    take;
	logic    issue;

	iol_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign load_ok   = !out_valid_q || rsp.ready;
	assign n7        = LEN_W'(count_q);
	assign cnt_m1    = count_q - CNT_W'(1);

	// Work out what the request asks for and whether it can be done.
	always_comb begin
		dec_ins  = 1'b0;
		dec_del  = 1'b0;
		dec_dump = 1'b0;
		dec_neg  = 1'b0;
		dec_pos  = '0;
		unique case (req.action)
			ACT_APPEND: begin
				dec_ins = 1'b1;
				dec_pos = n7;
			end
			ACT_FRONT: begin
				dec_ins = 1'b1;
			end
			ACT_INSERT: begin
				dec_ins = 1'b1;
				dec_neg = req.position[POS_W-1];
				dec_pos = LEN_W'(req.position[POS_W-2:0]);
			end
			ACT_DELETE: begin
				dec_del = 1'b1;
				dec_neg = req.position[POS_W-1];
				dec_pos = LEN_W'(req.position[POS_W-2:0]);
			end
			ACT_DUMP: begin
				dec_dump = 1'b1;
			end
			default: begin
			end
		endcase

		// Negative position first; insert: range, then full; delete: empty, then range.
		dec_status = STAT_OK;
		if (dec_ins) begin
			priority if (dec_neg) begin
				dec_status = STAT_BADPOS;
			end else if (dec_pos > n7) begin
				dec_status = STAT_BADPOS;
			end else if (count_q == CNT_W'(CAPACITY)) begin
				dec_status = STAT_FULL;
			end
		end else if (dec_del) begin
			priority if (dec_neg) begin
				dec_status = STAT_BADPOS;
			end else if (count_q == '0) begin
				dec_status = STAT_EMPTY;
			end else if (dec_pos >= n7) begin
				dec_status = STAT_BADPOS;
			end
		end
	end

	// Valid positions never exceed the length, so they fit the count width.
	assign dec_pos_c = CNT_W'(dec_pos);
	assign pos_p1    = dec_pos_c + CNT_W'(1);

	// Sequencer: decode, shift through the RAM, stream a dump, or finish an edit.
	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		stat_d       = stat_q;
		is_ins_d     = is_ins_q;
		is_del_d     = is_del_q;
		val_d        = val_q;
		pos_d        = pos_q;
		rd_ptr_d     = rd_ptr_q;
		rem_d        = rem_q;
		rd_pend_d    = 1'b0;
		wr_addr_d    = wr_addr_s1;
		last_d       = last_s1;
		ram_we       = 1'b0;
		ram_waddr    = wr_addr_s1;
		ram_wdata    = ram_rdata;
		ram_re       = 1'b0;
		ram_raddr    = rd_ptr_q;
		load         = 1'b0;
		out_status_d = STAT_OK;
		out_value_d  = '0;
		out_ivalid_d = 1'b0;
		out_last_d   = 1'b1;
		take         = 1'b0;
		issue        = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (accept && (dec_ins || dec_del || dec_dump)) begin
					stat_d   = dec_status;
					is_ins_d = 1'b0;
					is_del_d = 1'b0;
					val_d    = req.entry_value;
					pos_d    = dec_pos_c;
					state_d  = S_FINAL;
					if (dec_dump) begin
						// An empty dump answers like an edit with status ok.
						if (count_q != '0) begin
							rd_ptr_d = '0;
							rem_d    = count_q;
							state_d  = S_DUMP;
						end
					end else if (dec_status == STAT_OK) begin
						if (dec_ins) begin
							is_ins_d = 1'b1;
							rem_d    = count_q - dec_pos_c;
							rd_ptr_d = cnt_m1[ADDR_W-1:0];
							if (count_q != dec_pos_c) begin
								state_d = S_SHIFT;
							end
						end else begin
							is_del_d = 1'b1;
							rem_d    = cnt_m1 - dec_pos_c;
							rd_ptr_d = pos_p1[ADDR_W-1:0];
							if (cnt_m1 != dec_pos_c) begin
								state_d = S_SHIFT;
							end
						end
					end
				end
			end
			S_SHIFT: begin
				// Write back what was read last cycle, one slot up or down.
				ram_we = rd_pend_s1;
				if (rem_q != '0) begin
					ram_re    = 1'b1;
					rd_pend_d = 1'b1;
					rem_d     = rem_q - CNT_W'(1);
					if (is_ins_q) begin
						wr_addr_d = rd_ptr_q + ADDR_W'(1);
						rd_ptr_d  = rd_ptr_q - ADDR_W'(1);
					end else begin
						wr_addr_d = rd_ptr_q - ADDR_W'(1);
						rd_ptr_d  = rd_ptr_q + ADDR_W'(1);
					end
				end else begin
					state_d = S_FINAL;
				end
			end
			S_DUMP: begin
				take = rd_pend_s1 && load_ok;
				if (take) begin
					load         = 1'b1;
					out_value_d  = ram_rdata;
					out_ivalid_d = 1'b1;
					out_last_d   = last_s1;
				end
				// The RAM output holds its data until the next read, so a read is
				// issued only once the held entry has gone to the output register.
				issue = (rem_q != '0) && (!rd_pend_s1 || take);
				if (issue) begin
					ram_re    = 1'b1;
					rd_pend_d = 1'b1;
					last_d    = (rem_q == CNT_W'(1));
					rem_d     = rem_q - CNT_W'(1);
					rd_ptr_d  = rd_ptr_q + ADDR_W'(1);
				end else begin
					rd_pend_d = rd_pend_s1 && !take;
				end
				if ((rem_q == '0) && (!rd_pend_s1 || take)) begin
					state_d = S_IDLE;
				end
			end
			S_FINAL: begin
				if (load_ok) begin
					load         = 1'b1;
					out_status_d = stat_q;
					state_d      = S_IDLE;
					if (is_ins_q) begin
						ram_we    = 1'b1;
						ram_waddr = pos_q[ADDR_W-1:0];
						ram_wdata = val_q;
						count_d   = count_q + CNT_W'(1);
					end else if (is_del_q) begin
						count_d   = cnt_m1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rd_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			rd_pend_s1 <= rd_pend_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		stat_q     <= stat_d;
		is_ins_q   <= is_ins_d;
		is_del_q   <= is_del_d;
		val_q      <= val_d;
		pos_q      <= pos_d;
		rd_ptr_q   <= rd_ptr_d;
		rem_q      <= rem_d;
		wr_addr_s1 <= wr_addr_d;
		last_s1    <= last_d;
		if (load) begin
			out_status_q <= out_status_d;
			out_value_q  <= out_value_d;
			out_ivalid_q <= out_ivalid_d;
			out_last_q   <= out_last_d;
			out_len_q    <= LEN_W'(count_d);
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.item_value = out_value_q;
	assign rsp.item_valid = out_ivalid_q;
	assign rsp.last_item  = out_last_q;
	assign rsp.length     = out_len_q;

`ifndef SYNTH
	// The list never holds more than its capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("list length above capacity");

	// The length changes only when an edit completes.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_FINAL) |=> $stable(count_q))
		else $error("list length changed outside edit completion");

	// A shift never reads and writes the same RAM entry in one cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("RAM read and write collide on one entry");

	// Read data is only in flight while shifting or dumping.
	assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> ((state_q == S_SHIFT) || (state_q == S_DUMP)))
		else $error("RAM read pending outside shift or dump");
`endif

endmodule

// ===== design/iol_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module iol_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== bench/indexed_ordered_list_test.sv =====
// Self-checking testbench for the indexed ordered list: list predictor, response checks.
module indexed_ordered_list_test;
	import iol_pkg::*;

	// Action codes that the block drops without a response.
	localparam logic [ACTION_W-1:0] ACT_SPARE_FIRST = 3'd5;
	localparam logic [ACTION_W-1:0] ACT_SPARE_LAST  = 3'd7;

	localparam int RANDOM_ITEMS = 500;
	// Cycles without any handshake before the run is declared hung. A dump of a
	// full list with receiver stalls stays far below this.
	localparam int STALL_LIMIT  = 1000;

	// One response item as the predictor expects it.
	typedef struct packed {
		status_t          status;
		data_t            value;
		logic             item_valid;
		logic             last_item;
		logic [LEN_W-1:0] length;
	} list_result_t;

	// Shadow copy of the list. Every accepted request is applied here and the
	// responses it must cause are queued in order; every accepted response is
	// checked against the oldest queued one.
	class list_scoreboard;
		data_t        entries [CAPACITY];
		int           count;
		list_result_t pending_results [$];
		int           errors;
		int           requests;
		int           results;
		int           dumps;
		int           peak;
		int           status_seen [4];

		function void push(status_t st, data_t val, logic vld, logic lst);
			list_result_t r;
			r.status     = st;
			r.value      = val;
			r.item_valid = vld;
			r.last_item  = lst;
			r.length     = LEN_W'(count);
			pending_results.push_back(r);
		endfunction

		// Insert ahead of the entry at position at, moving the tail up one slot.
		// The position test comes before the capacity test.
		function status_t insert_at(int at, data_t val);
			if (at > count)
				return STAT_BADPOS;
			if (count >= CAPACITY)
				return STAT_FULL;
			for (int i = count; i > at; i--)
				entries[i] = entries[i - 1];
			entries[at] = val;
			count++;
			return STAT_OK;
		endfunction

		function void note_request(logic [ACTION_W-1:0] act, data_t val,
				logic [POS_W-1:0] pos);
			status_t st;
			int      at;
			at = int'(pos[POS_W-2:0]);
			requests++;
			case (act)
				ACT_APPEND: st = insert_at(count, val);
				ACT_FRONT:  st = insert_at(0, val);
				ACT_INSERT: st = pos[POS_W-1] ? STAT_BADPOS : insert_at(at, val);
				ACT_DELETE: begin
					// A negative position is rejected even on an empty list.
					if (pos[POS_W-1])
						st = STAT_BADPOS;
					else if (count == 0)
						st = STAT_EMPTY;
					else if (at >= count)
						st = STAT_BADPOS;
					else begin
						for (int i = at; i + 1 < count; i++)
							entries[i] = entries[i + 1];
						count--;
						st = STAT_OK;
					end
				end
				ACT_DUMP: begin
					dumps++;
					if (count == 0)
						push(STAT_OK, '0, 1'b0, 1'b1);
					else
						for (int i = 0; i < count; i++)
							push(STAT_OK, entries[i], 1'b1, i == count - 1);
					return;
				end
				default: return;
			endcase
			status_seen[st]++;
			if (count > peak)
				peak = count;
			push(st, '0, 1'b0, 1'b1);
		endfunction

		function void compare_field(string name, logic [DATA_W-1:0] want_v,
				logic [DATA_W-1:0] got_v);
			if (want_v !== got_v) begin
				errors++;
				$display("%0t: %s expected %0h, actual %0h", $time, name, want_v, got_v);
			end
		endfunction

		function void check_result(list_result_t got);
			list_result_t want;
			results++;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: response with nothing pending: status %0d value %0h length %0d",
					$time, got.status, got.value, got.length);
				return;
			end
			want = pending_results.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("item_value", want.value, got.value);
			compare_field("item_valid", want.item_valid, got.item_valid);
			compare_field("last_item", want.last_item, got.last_item);
			compare_field("length", want.length, got.length);
		endfunction
	endclass

	logic           clk;
	logic           arst_n;
	bit             quiet;
	int             idle_cycles;
	list_scoreboard board;

	iol_req_if req_ch ();
	iol_rsp_if rsp_ch ();

	indexed_ordered_list dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Offer one request item and hold it until the block takes it. Called at a
	// falling edge and returns at the falling edge after the handshake, so the
	// next item follows back to back unless a random gap is drawn. Outside the
	// quiet stretch about one cycle in five is left empty.
	task automatic send_item(input logic [ACTION_W-1:0] act, input data_t val,
			input logic [POS_W-1:0] pos);
		while (!quiet && $urandom_range(0, 99) < 20) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.action      <= act;
		req_ch.entry_value <= val;
		req_ch.position    <= pos;
		do
			@(posedge clk);
		while (!req_ch.ready);
		@(negedge clk);
	endtask

	// The response side drops ready in about one cycle in five, except in the
	// quiet stretch, so stalls land on every phase of shifts and dumps.
	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			rsp_ch.ready <= quiet || ($urandom_range(0, 99) >= 20);
		end
	end

	// Both channels are sampled at the rising edge, when the falling-edge drive
	// has long settled.
	always @(posedge clk) begin
		list_result_t seen;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				board.note_request(req_ch.action, req_ch.entry_value, req_ch.position);
			if (rsp_ch.valid && rsp_ch.ready) begin
				seen.status     = status_t'(rsp_ch.status);
				seen.value      = rsp_ch.item_value;
				seen.item_valid = rsp_ch.item_valid;
				seen.last_item  = rsp_ch.last_item;
				seen.length     = rsp_ch.length;
				board.check_result(seen);
			end
		end
	end

	// Watchdog: any handshake on either channel restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no handshake for %0d cycles, %0d responses outstanding",
				$time, STALL_LIMIT, board.pending_results.size());
			$display("indexed_ordered_list: mismatch");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		logic [ACTION_W-1:0] act;
		logic [POS_W-1:0]    pos;
		data_t               val;
		int                  sent;
		int                  pick;
		int                  grow_pct;

		board              = new();
		quiet              = 1'b0;
		idle_cycles        = 0;
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.action      = ACT_APPEND;
		req_ch.entry_value = '0;
		req_ch.position    = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part. On the empty list: a dump gives its single invalid item, a delete
		// reports the list empty, but a negative position is reported as a bad position first,
		// and inserts at a negative position or past the end are bad positions too.
		send_item(ACT_DUMP, '0, '0);
		send_item(ACT_DELETE, '0, 8'd0);
		send_item(ACT_DELETE, '0, 8'hFF);
		send_item(ACT_INSERT, 32'h1234_5678, 8'h80);
		send_item(ACT_INSERT, 32'h1234_5678, 8'd1);
		// Spare action codes must vanish without a response.
		for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++)
			send_item(ACTION_W'(a), 32'hFFFF_FFFF, 8'hFF);
		// Value extremes at both ends and in the middle, then the edges of
		// the legal position ranges for insert and delete.
		send_item(ACT_APPEND, 32'h8000_0000, '0);
		send_item(ACT_FRONT, 32'h7FFF_FFFF, '0);
		send_item(ACT_INSERT, 32'h0000_0000, 8'd2);
		send_item(ACT_INSERT, 32'hFFFF_FFFF, 8'd1);
		send_item(ACT_INSERT, 32'h5555_AAAA, 8'h7F);
		send_item(ACT_DELETE, '0, 8'd4);
		send_item(ACT_DELETE, '0, 8'd3);
		send_item(ACT_DELETE, '0, 8'd0);
		send_item(ACT_DUMP, '0, '0);
		// Fill to capacity; every kind of insert must then report the list
		// full, while a position past the end is still a bad position.
		while (board.count < CAPACITY)
			send_item(ACT_APPEND, $urandom, '0);
		send_item(ACT_APPEND, 32'h0BAD_F00D, '0);
		send_item(ACT_FRONT, 32'h0BAD_F00D, '0);
		send_item(ACT_INSERT, 32'h0BAD_F00D, 8'(CAPACITY));
		send_item(ACT_INSERT, 32'h0BAD_F00D, 8'(CAPACITY + 1));
		send_item(ACT_DUMP, '0, '0);
		send_item(ACT_DELETE, '0, 8'(CAPACITY - 1));
		send_item(ACT_DELETE, '0, 8'd0);

		// Random part in phases of 60 items: one favors inserts so the list
		// runs into full, one favors deletes so it drains to empty, one is
		// balanced. Most positions are legal for the current length; the rest
		// span the whole 8-bit field. Spare codes do not count as items.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			quiet    = (sent >= 220 && sent < 300);
			grow_pct = ((sent / 60) % 3 == 0) ? 85 : ((sent / 60) % 3 == 1) ? 20 : 55;
			pick     = $urandom_range(0, 99);
			if (pick >= 97)
				act = ACTION_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
			else if (pick >= 88)
				act = ACT_DUMP;
			else if ($urandom_range(0, 99) < grow_pct) begin
				case ($urandom_range(0, 2))
					0:       act = ACT_APPEND;
					1:       act = ACT_FRONT;
					default: act = ACT_INSERT;
				endcase
			end else
				act = ACT_DELETE;

			if ($urandom_range(0, 99) < 12)
				pos = POS_W'($urandom_range(0, 255));
			else if (act == ACT_DELETE && board.count > 0)
				pos = POS_W'($urandom_range(0, board.count - 1));
			else
				pos = POS_W'($urandom_range(0, board.count));

			case ($urandom_range(0, 9))
				0:       val = 32'h8000_0000;
				1:       val = 32'h7FFF_FFFF;
				default: val = $urandom;
			endcase

			send_item(act, val, pos);
			if (act <= ACT_DUMP)
				sent++;
		end
		quiet = 1'b0;
		req_ch.valid <= 1'b0;

		// Drain, then leave room for any stray response to show up.
		while (board.pending_results.size() != 0)
			@(posedge clk);
		repeat (2 * CAPACITY) @(posedge clk);

		$display("Run covered %0d requests, %0d responses and %0d dumps; peak length %0d.",
			board.requests, board.results, board.dumps, board.peak);
		$display("Edit outcomes: ok %0d, bad position %0d, empty %0d, full %0d.",
			board.status_seen[STAT_OK], board.status_seen[STAT_BADPOS],
			board.status_seen[STAT_EMPTY], board.status_seen[STAT_FULL]);
		if (board.errors == 0 && board.pending_results.size() == 0)
			$display("indexed_ordered_list: match");
		else
			$display("indexed_ordered_list: mismatch");
		$finish;
	end

endmodule
